[hdl/spf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants
// Table geometry, controller states, and the command and status groups that
// pass between the sieve/factorizer controller and its datapath.
// ----------------------------------------------------------------------------
package spf_pkg;

    // Table size as configured; only entries reachable by a 16-bit input are kept
    localparam int TABLE_BITS  = 16;
    localparam int NUMBER_BITS = 16;
    localparam int PRIME_BITS  = 16;
    localparam int EXP_BITS    = 5;

    localparam int ADDR_BITS   = (TABLE_BITS < NUMBER_BITS) ? TABLE_BITS : NUMBER_BITS;
    localparam int TABLE_DEPTH = 1 << ADDR_BITS;

    // Stored factor never exceeds sqrt(depth); cofactor fits the address width
    localparam int P_BITS  = (ADDR_BITS + 1) / 2;
    localparam int Q_BITS  = ADDR_BITS;
    localparam int I_BITS  = P_BITS + 1;
    localparam int SQ_BITS = 2 * I_BITS;
    localparam int J_BITS  = ADDR_BITS + 1;

    // Table entry: smallest factor (zero = unmarked, value is prime) and cofactor
    typedef struct packed {
        logic [P_BITS-1:0] p;
        logic [Q_BITS-1:0] q;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_PRIME_RD,
        ST_PRIME_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_IDLE,
        ST_STEP,
        ST_FINAL,
        ST_EMPTY
    } state_t;

    typedef enum logic [2:0] {
        ADDR_CLR,
        ADDR_I,
        ADDR_J,
        ADDR_NUM,
        ADDR_Q
    } addr_sel_t;

    typedef enum logic [1:0] {
        OUT_MID,
        OUT_FINAL,
        OUT_EMPTY
    } out_kind_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      mem_rd;
        logic      mem_wr;
        logic      wr_mark;
        logic      clr_inc;
        logic      load_i2;
        logic      i_inc;
        logic      load_j;
        logic      j_inc;
        logic      load_num;
        logic      step;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic sq_ge_n;
        logic entry_zero;
        logic j_ge_n;
        logic num_empty;
        logic need_emit;
        logic q_is_one;
        logic out_free;
    } status_t;

endpackage

[hdl/spf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_ctrl: sequencer for clear, sieve and factorization
// Clears the table, runs the sieve from each prime's square, then walks the
// factor chain of each accepted item and schedules its results.
// ----------------------------------------------------------------------------
module spf_ctrl
    import spf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = ADDR_CLR;
        cmd.out_kind = OUT_MID;
        s_ready      = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                cmd.mem_wr  = 1'b1;
                cmd.clr_inc = 1'b1;
                if (status.clr_done) begin
                    cmd.load_i2 = 1'b1;
                    state_next  = ST_PRIME_RD;
                end
            end

            // Sieve outer loop: stop once i*i passes the table
            ST_PRIME_RD: begin
                if (status.sq_ge_n) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.addr_sel = ADDR_I;
                    cmd.mem_rd   = 1'b1;
                    state_next   = ST_PRIME_CHK;
                end
            end

            ST_PRIME_CHK: begin
                if (status.entry_zero) begin
                    cmd.load_j = 1'b1;
                    state_next = ST_MARK_RD;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_PRIME_RD;
                end
            end

            // Mark multiples still unmarked
            ST_MARK_RD: begin
                if (status.j_ge_n) begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_PRIME_RD;
                end else begin
                    cmd.addr_sel = ADDR_J;
                    cmd.mem_rd   = 1'b1;
                    state_next   = ST_MARK_WR;
                end
            end

            ST_MARK_WR: begin
                cmd.addr_sel = ADDR_J;
                cmd.mem_wr   = status.entry_zero;
                cmd.wr_mark  = 1'b1;
                cmd.j_inc    = 1'b1;
                state_next   = ST_MARK_RD;
            end

            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_num = 1'b1;
                    if (status.num_empty) begin
                        state_next = ST_EMPTY;
                    end else begin
                        cmd.addr_sel = ADDR_NUM;
                        cmd.mem_rd   = 1'b1;
                        state_next   = ST_STEP;
                    end
                end
            end

            // One lookup per cycle; hold while a finished prime cannot be sent
            ST_STEP: begin
                if (!(status.need_emit && !status.out_free)) begin
                    cmd.step     = 1'b1;
                    cmd.out_load = status.need_emit;
                    cmd.out_kind = OUT_MID;
                    if (status.q_is_one) begin
                        state_next = ST_FINAL;
                    end else begin
                        cmd.addr_sel = ADDR_Q;
                        cmd.mem_rd   = 1'b1;
                    end
                end
            end

            ST_FINAL: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_FINAL;
                    state_next   = ST_IDLE;
                end
            end

            ST_EMPTY: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_EMPTY;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[hdl/spf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_datapath: factor table, sieve counters and factorization registers
// Single-port table with registered read, the sieve index and multiple
// counters, the running remainder and exponent, and the result register.
// ----------------------------------------------------------------------------
module spf_datapath
    import spf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [NUMBER_BITS-1:0] s_number,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PRIME_BITS-1:0]  m_prime,
    output logic [EXP_BITS-1:0]    m_exponent,
    output logic                   m_last,
    output logic                   m_empty_res
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;

    logic [ADDR_BITS-1:0] clr_reg;
    logic [I_BITS-1:0]    i_reg;
    logic [J_BITS-1:0]    j_reg;
    logic [Q_BITS-1:0]    k_reg;
    logic [ADDR_BITS-1:0] rem_reg;
    logic [ADDR_BITS-1:0] cur_p_reg;
    logic [EXP_BITS-1:0]  exp_reg;

    logic                  m_valid_reg;
    logic [PRIME_BITS-1:0] m_prime_reg;
    logic [EXP_BITS-1:0]   m_exponent_reg;
    logic                  m_last_reg;
    logic                  m_empty_res_reg;

    logic [SQ_BITS-1:0]   sq;
    logic                 entry_zero;
    logic [ADDR_BITS-1:0] prime_now;
    logic [Q_BITS-1:0]    q_now;
    logic                 need_emit;
    logic                 out_free;
    logic [ADDR_BITS-1:0] addr;
    entry_t               wr_data;

    // Decode of the last table read
    assign sq         = i_reg * i_reg;
    assign entry_zero = (rd_reg.p == '0);
    assign prime_now  = entry_zero ? rem_reg : ADDR_BITS'(rd_reg.p);
    assign q_now      = entry_zero ? Q_BITS'(1) : rd_reg.q;
    assign need_emit  = (exp_reg != '0) && (prime_now != cur_p_reg);
    assign out_free   = !m_valid_reg || m_ready;

    // Table address and write data
    always_comb begin
        case (cmd.addr_sel)
            ADDR_CLR: addr = clr_reg;
            ADDR_I:   addr = ADDR_BITS'(i_reg);
            ADDR_J:   addr = j_reg[ADDR_BITS-1:0];
            ADDR_NUM: addr = s_number[ADDR_BITS-1:0];
            ADDR_Q:   addr = q_now;
            default:  addr = clr_reg;
        endcase
        wr_data = '0;
        if (cmd.wr_mark) begin
            wr_data.p = i_reg[P_BITS-1:0];
            wr_data.q = k_reg;
        end
    end

    // Factor table
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_reg <= mem[addr];
        end
    end

    // Sieve counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_inc) begin
            clr_reg <= clr_reg + 1'b1;
        end
        if (cmd.load_i2) begin
            i_reg <= I_BITS'(2);
        end else if (cmd.i_inc) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.load_j) begin
            j_reg <= J_BITS'(sq);
            k_reg <= Q_BITS'(i_reg);
        end else if (cmd.j_inc) begin
            j_reg <= j_reg + J_BITS'(i_reg);
            k_reg <= k_reg + 1'b1;
        end
    end

    // Remainder, current prime and its exponent
    always_ff @(posedge aclk) begin
        if (cmd.load_num) begin
            rem_reg <= s_number[ADDR_BITS-1:0];
            exp_reg <= '0;
        end else if (cmd.step) begin
            rem_reg   <= q_now;
            cur_p_reg <= prime_now;
            if (need_emit || exp_reg == '0) begin
                exp_reg <= EXP_BITS'(1);
            end else begin
                exp_reg <= exp_reg + 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            case (cmd.out_kind)
                OUT_MID: begin
                    m_prime_reg     <= PRIME_BITS'(cur_p_reg);
                    m_exponent_reg  <= exp_reg;
                    m_last_reg      <= 1'b0;
                    m_empty_res_reg <= 1'b0;
                end
                OUT_FINAL: begin
                    m_prime_reg     <= PRIME_BITS'(cur_p_reg);
                    m_exponent_reg  <= exp_reg;
                    m_last_reg      <= 1'b1;
                    m_empty_res_reg <= 1'b0;
                end
                default: begin
                    m_prime_reg     <= '0;
                    m_exponent_reg  <= '0;
                    m_last_reg      <= 1'b1;
                    m_empty_res_reg <= 1'b1;
                end
            endcase
        end
    end

    // Status back to the controller
    always_comb begin
        status            = '0;
        status.clr_done   = (clr_reg == '1);
        status.sq_ge_n    = (sq >= SQ_BITS'(TABLE_DEPTH));
        status.entry_zero = entry_zero;
        status.j_ge_n     = j_reg[ADDR_BITS];
        status.num_empty  = (s_number < NUMBER_BITS'(2))
                         || ({1'b0, s_number} >= (NUMBER_BITS + 1)'(TABLE_DEPTH));
        status.need_emit  = need_emit;
        status.q_is_one   = (q_now == Q_BITS'(1));
        status.out_free   = out_free;
    end

    assign m_valid     = m_valid_reg;
    assign m_prime     = m_prime_reg;
    assign m_exponent  = m_exponent_reg;
    assign m_last      = m_last_reg;
    assign m_empty_res = m_empty_res_reg;

endmodule

[hdl/smallest_prime_factor_sieve_factorizer_top.sv]
`timescale 1ns / 1ps
// Timing: an empty item is sent from ST_EMPTY once the result register is free;
// otherwise one table lookup per cycle, held while a finished prime cannot be sent
// (one per prime factor with multiplicity, at most 15), then ST_FINAL emits the last.
// Throughput: one item at a time, set by the single-port factor table lookup chain.
// Reset: a clearing pass over every table entry, then the sieve over primes p below
// 256; s_ready stays low until done.
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_factorizer_top: sieve-based factorizer
// Builds a smallest-factor table after reset, then emits one item per distinct prime
// of each number, ascending, with exponent and last flag, or one empty item below 2.
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve_factorizer_top
    import spf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [NUMBER_BITS-1:0] s_number,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PRIME_BITS-1:0]  m_prime,
    output logic [EXP_BITS-1:0]    m_exponent,
    output logic                   m_last,
    output logic                   m_empty_res
);

    cmd_t    cmd;
    status_t status;

    spf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    spf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_number    (s_number),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_prime     (m_prime),
        .m_exponent  (m_exponent),
        .m_last      (m_last),
        .m_empty_res (m_empty_res)
    );

endmodule
